[rtl/core/ghrq_pkg.sv]
// ----------------------------------------------------------------------------
// Grid hash radius query package
// Shared constants and types for the grid point store.
// ----------------------------------------------------------------------------
package ghrq_pkg;

  localparam int AxisCellsMax = 16;
  localparam int BucketDepth  = 8;
  localparam int CoordBits    = 20;

  localparam int AxisBits  = $clog2(AxisCellsMax);
  localparam int SlotBits  = 3 * AxisBits;
  localparam int SlotCount = AxisCellsMax * AxisCellsMax * AxisCellsMax;
  localparam int EntBits   = (BucketDepth > 1) ? $clog2(BucketDepth) : 1;
  localparam int FillBits  = $clog2(BucketDepth + 1);
  localparam int PtAddrW   = SlotBits + EntBits;
  localparam int PtDepth   = SlotCount * (1 << EntBits);
  localparam int PtWidth   = 3 * CoordBits;
  localparam int SizeBits  = CoordBits - 1;
  localparam int CntBits   = 5;
  localparam int DiffBits  = CoordBits + 1;
  localparam int QuoBits   = DiffBits;
  localparam int SqBits    = 2 * DiffBits;
  localparam int SumBits   = SqBits + 2;
  localparam int IdxBits   = AxisBits + 2;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_ORIGIN_Z  = 3'd2,
    CFG_CELL_SIZE = 3'd3,
    CFG_CELLS_X   = 3'd4,
    CFG_CELLS_Y   = 3'd5,
    CFG_CELLS_Z   = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic                 start;
    logic signed [DiffBits-1:0] num;
    logic [SizeBits-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [QuoBits-1:0]  quo;
  } div_rsp_t;

endpackage

[rtl/core/ghrq_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module ghrq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/ghrq_div.sv]
// ----------------------------------------------------------------------------
// Grid hash floor divider
// Restoring divider, one quotient bit per cycle, floor rounding for signed
// numerators and a positive divisor.
// ----------------------------------------------------------------------------
module ghrq_div
  import ghrq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int StepBits = $clog2(QuoBits + 1);

  logic [QuoBits-1:0]  mag_r, mag_nxt;
  logic [SizeBits:0]   rem_r, rem_nxt;
  logic [SizeBits-1:0] den_r, den_nxt;
  logic                neg_r, neg_nxt;
  logic [StepBits-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [SizeBits:0]   shifted;
  logic [SizeBits:0]   trial;
  logic                rem_nz;
  logic [QuoBits-1:0]  qmag;

  always_comb begin
    shifted  = {rem_r[SizeBits-1:0], mag_r[QuoBits-1]};
    trial    = shifted - {1'b0, den_r};
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      neg_nxt  = req.num[DiffBits-1];
      mag_nxt  = req.num[DiffBits-1] ? QuoBits'(-req.num) : QuoBits'(req.num);
      den_nxt  = (req.den == '0) ? SizeBits'(1) : req.den;
      rem_nxt  = '0;
      cnt_nxt  = StepBits'(QuoBits);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[SizeBits]) begin
        rem_nxt = trial;
        mag_nxt = {mag_r[QuoBits-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        mag_nxt = {mag_r[QuoBits-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - StepBits'(1);
      if (cnt_r == StepBits'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign rem_nz   = (rem_r != '0);
  assign qmag     = mag_r + QuoBits'(neg_r && rem_nz);
  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? -$signed(qmag) : $signed(qmag);

endmodule

[rtl/core/ghrq_dist.sv]
// ----------------------------------------------------------------------------
// Grid hash distance unit
// Shared square unit: one axis difference squared per cycle, accumulated
// into a squared distance.
// ----------------------------------------------------------------------------
module ghrq_dist
  import ghrq_pkg::*;
(
  input  logic                        clk,
  input  logic                        clr,
  input  logic                        acc,
  input  logic signed [CoordBits-1:0] a,
  input  logic signed [CoordBits-1:0] b,
  output logic [SumBits-1:0]          sum
);

  logic signed [DiffBits-1:0] diff;
  logic [DiffBits-1:0]        mag;
  logic [SqBits-1:0]          sq_r;
  logic                       acc_r;
  logic [SumBits-1:0]         sum_r, sum_nxt;

  assign diff = DiffBits'(a) - DiffBits'(b);
  assign mag  = diff[DiffBits-1] ? DiffBits'(-diff) : DiffBits'(diff);

  always_comb begin
    sum_nxt = sum_r;
    if (clr) begin
      sum_nxt = '0;
    end else if (acc_r) begin
      sum_nxt = sum_r + SumBits'(sq_r);
    end
  end

  always_ff @(posedge clk) begin
    sq_r  <= mag * mag;
    acc_r <= acc;
    sum_r <= sum_nxt;
  end

  assign sum = sum_r;

endmodule

[rtl/core/grid_hash_radius_query.sv]
// ----------------------------------------------------------------------------
// Grid hash radius query
// Uniform 3D grid point store with add and fixed-radius nearness query.
// ----------------------------------------------------------------------------
// Channel | Direction | Signals
// in      | input     | in_kind, in_x, in_y, in_z, in_distance
// out     | output    | out_found, out_status
// cfg     | input     | cfg_index, cfg_data
//
// After reset a clearing pass zeroes the 4096 fill counts, one per cycle;
// no item is accepted meanwhile. An item runs three serial floor
// divisions, then an add or a query follows; a query steps through the
// neighbor cells and their stored points one at a time, paced by the
// single point RAM read port and the shared square unit. The result waits
// in an output register while the next item runs; a later result holds in
// the last state until that register is taken.
// ----------------------------------------------------------------------------
module grid_hash_radius_query
  import ghrq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [CoordBits-1:0] in_x,
  input  logic [CoordBits-1:0] in_y,
  input  logic [CoordBits-1:0] in_z,
  input  logic [SizeBits-1:0]  in_distance,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_found,
  output logic [1:0]           out_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [CoordBits-1:0] cfg_data
);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_DIV   = 12'b000000000100,
    S_CHECK = 12'b000000001000,
    S_FILL  = 12'b000000010000,
    S_FILLW = 12'b000000100000,
    S_ADD   = 12'b000001000000,
    S_NBR   = 12'b000010000000,
    S_PREAD = 12'b000100000000,
    S_PAXIS = 12'b001000000000,
    S_PCMP  = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [CoordBits-1:0] org_r [3];
  logic [SizeBits-1:0]         csize_r;
  logic [CntBits-1:0]          cells_r [3];

  logic                        kind_r;
  logic signed [CoordBits-1:0] pt_r [3];
  logic [SizeBits-1:0]         dist_r;
  logic signed [QuoBits-1:0]   idx_r [3];
  logic [1:0]                  axis_r, axis_nxt;
  logic [1:0]                  off_r [3];
  logic [1:0]                  off_nxt [3];
  logic [EntBits:0]            ent_r, ent_nxt;
  logic [FillBits-1:0]         nfill_r;
  logic [SlotBits-1:0]         clr_r;
  logic [SumBits-1:0]          d2_r;
  logic [SlotBits-1:0]         slot_r;
  logic                        found_r, found_nxt;
  logic [1:0]                  status_r, status_nxt;
  logic                        ovalid_r, ovalid_nxt;
  logic                        res_found_r;
  logic [1:0]                  res_status_r;
  logic                        res_load;

  div_req_t dreq;
  div_rsp_t drsp;

  logic [CntBits-1:0]        lim [3];
  logic signed [IdxBits-1:0] nb [3];
  logic                      nb_ok;
  logic                      in_grid;
  logic [SlotBits-1:0]       nslot;
  logic [SlotBits-1:0]       own_slot;
  logic [FillBits-1:0]       fill_cnt;
  logic [2*SizeBits-1:0]     dsq;

  logic                  fill_we;
  logic [SlotBits-1:0]   fill_wa, fill_ra;
  logic [FillBits-1:0]   fill_wd, fill_rd;
  logic                  pt_we;
  logic [PtAddrW-1:0]    pt_wa, pt_ra;
  logic [PtWidth-1:0]    pt_rd;

  logic                        dclr, dacc;
  logic signed [CoordBits-1:0] da, db;
  logic [SumBits-1:0]          dsum;
  logic [1:0]                  pax_r, pax_nxt;

  logic in_acc, out_acc;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign fill_cnt  = (ent_r == '0) ? fill_rd : nfill_r;
  assign dsq       = dist_r * dist_r;
  assign res_load  = (state_r == S_DONE) && (!ovalid_r || out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      csize_r  <= SizeBits'(256);
      cells_r[0] <= CntBits'(16);
      cells_r[1] <= CntBits'(16);
      cells_r[2] <= CntBits'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIGIN_X:  org_r[0] <= cfg_data;
        CFG_ORIGIN_Y:  org_r[1] <= cfg_data;
        CFG_ORIGIN_Z:  org_r[2] <= cfg_data;
        CFG_CELL_SIZE: csize_r <= cfg_data[SizeBits-1:0];
        CFG_CELLS_X:   cells_r[0] <= cfg_data[CntBits-1:0];
        CFG_CELLS_Y:   cells_r[1] <= cfg_data[CntBits-1:0];
        CFG_CELLS_Z:   cells_r[2] <= cfg_data[CntBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_grid = 1'b1;
    nb_ok   = 1'b1;
    for (int a = 0; a < 3; a++) begin
      lim[a] = (cells_r[a] > CntBits'(AxisCellsMax)) ? CntBits'(AxisCellsMax) : cells_r[a];
      if (idx_r[a] < 0 || idx_r[a] >= $signed({1'b0, lim[a]})) begin
        in_grid = 1'b0;
      end
      nb[a] = IdxBits'(idx_r[a]) + IdxBits'(off_r[a]) - IdxBits'(1);
      if (nb[a] < 0 || nb[a] >= $signed(IdxBits'(lim[a]))) begin
        nb_ok = 1'b0;
      end
    end
    own_slot = {idx_r[0][AxisBits-1:0], idx_r[1][AxisBits-1:0], idx_r[2][AxisBits-1:0]};
    nslot    = {nb[0][AxisBits-1:0], nb[1][AxisBits-1:0], nb[2][AxisBits-1:0]};
  end

  ghrq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  ghrq_ram #(.Width(FillBits), .Depth(SlotCount)) u_fill (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_wa),
    .wdata (fill_wd),
    .raddr (fill_ra),
    .rdata (fill_rd)
  );

  ghrq_ram #(.Width(PtWidth), .Depth(PtDepth)) u_pts (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_wa),
    .wdata ({pt_r[2], pt_r[1], pt_r[0]}),
    .raddr (pt_ra),
    .rdata (pt_rd)
  );

  ghrq_dist u_dist (
    .clk (clk),
    .clr (dclr),
    .acc (dacc),
    .a   (da),
    .b   (db),
    .sum (dsum)
  );

  always_comb begin
    case (pax_r)
      2'd0:    da = pt_rd[CoordBits-1:0];
      2'd1:    da = pt_rd[2*CoordBits-1:CoordBits];
      default: da = pt_rd[3*CoordBits-1:2*CoordBits];
    endcase
    db = pt_r[pax_r];
  end

  always_comb begin
    state_nxt  = state_r;
    axis_nxt   = axis_r;
    off_nxt    = off_r;
    ent_nxt    = ent_r;
    pax_nxt    = pax_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    ovalid_nxt = ovalid_r && !out_acc;
    dreq.start = 1'b0;
    dreq.num   = DiffBits'(pt_r[axis_r]) - DiffBits'(org_r[axis_r]);
    dreq.den   = csize_r;
    fill_we    = 1'b0;
    fill_wa    = own_slot;
    fill_wd    = nfill_r + FillBits'(1);
    fill_ra    = own_slot;
    pt_we      = 1'b0;
    pt_wa      = {own_slot, nfill_r[EntBits-1:0]};
    pt_ra      = {slot_r, ent_r[EntBits-1:0]};
    dclr       = 1'b0;
    dacc       = 1'b0;
    case (state_r)
      S_CLEAR: begin
        fill_we = 1'b1;
        fill_wa = clr_r;
        fill_wd = '0;
        if (clr_r == SlotBits'(SlotCount - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          axis_nxt  = 2'd0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        dreq.start = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        if (drsp.done) begin
          if (axis_r == 2'd2) begin
            found_nxt  = 1'b0;
            status_nxt = ST_OK;
            state_nxt  = S_FILL;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_DIV;
          end
        end
      end
      S_FILL: begin
        if (!in_grid) begin
          status_nxt = ST_OUTSIDE;
          state_nxt  = S_DONE;
        end else if (!kind_r) begin
          state_nxt = S_FILLW;
        end else begin
          off_nxt[0] = 2'd0;
          off_nxt[1] = 2'd0;
          off_nxt[2] = 2'd0;
          state_nxt  = S_NBR;
        end
      end
      S_FILLW: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (nfill_r >= FillBits'(BucketDepth)) begin
          status_nxt = ST_FULL;
        end else begin
          fill_we = 1'b1;
          pt_we   = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_NBR: begin
        fill_ra = nslot;
        ent_nxt = '0;
        if (nb_ok) begin
          state_nxt = S_PREAD;
        end else begin
          state_nxt = S_PCMP;
          ent_nxt   = '1;
        end
      end
      S_PREAD: begin
        if (ent_r >= (EntBits+1)'(fill_cnt) || ent_r >= (EntBits+1)'(BucketDepth)) begin
          ent_nxt   = '1;
          state_nxt = S_PCMP;
        end else begin
          pax_nxt   = 2'd0;
          dclr      = 1'b1;
          state_nxt = S_PAXIS;
        end
      end
      S_PAXIS: begin
        dacc = 1'b1;
        if (pax_r == 2'd2) begin
          state_nxt = S_PCMP;
        end else begin
          pax_nxt = pax_r + 2'd1;
        end
      end
      S_PCMP: begin
        if (ent_r != '1) begin
          if (dsum < d2_r) begin
            found_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            ent_nxt   = ent_r + (EntBits+1)'(1);
            state_nxt = S_PREAD;
          end
        end else begin
          state_nxt = S_DONE;
          if (off_r[2] != 2'd2) begin
            off_nxt[2] = off_r[2] + 2'd1;
            state_nxt  = S_NBR;
          end else if (off_r[1] != 2'd2) begin
            off_nxt[2] = 2'd0;
            off_nxt[1] = off_r[1] + 2'd1;
            state_nxt  = S_NBR;
          end else if (off_r[0] != 2'd2) begin
            off_nxt[2] = 2'd0;
            off_nxt[1] = 2'd0;
            off_nxt[0] = off_r[0] + 2'd1;
            state_nxt  = S_NBR;
          end
        end
      end
      S_DONE: begin
        if (!ovalid_r || out_acc) begin
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // pcmp_wait_r holds the compare in S_PCMP until the last square has been summed.
  logic pcmp_wait_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      ovalid_r    <= 1'b0;
      pcmp_wait_r <= 1'b0;
    end else begin
      if (state_r == S_PCMP && ent_r != '1 && !pcmp_wait_r) begin
        pcmp_wait_r <= 1'b1;
      end else begin
        state_r     <= state_nxt;
        pcmp_wait_r <= 1'b0;
      end
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + SlotBits'(1);
      end
      ovalid_r <= ovalid_nxt;
    end
    if (!(state_r == S_PCMP && ent_r != '1 && !pcmp_wait_r)) begin
      axis_r   <= axis_nxt;
      off_r    <= off_nxt;
      ent_r    <= ent_nxt;
      pax_r    <= pax_nxt;
      found_r  <= found_nxt;
      status_r <= status_nxt;
    end
    if (in_acc) begin
      kind_r   <= in_kind;
      pt_r[0]  <= in_x;
      pt_r[1]  <= in_y;
      pt_r[2]  <= in_z;
      dist_r   <= in_distance;
    end
    if (state_r == S_FILL) begin
      d2_r <= SumBits'(dsq);
    end
    if (drsp.done) begin
      idx_r[axis_r] <= drsp.quo;
    end
    if (state_r == S_NBR) begin
      slot_r <= nslot;
    end
    if (state_r == S_FILLW || state_r == S_PREAD && ent_r == '0) begin
      nfill_r <= fill_rd;
    end
    if (res_load) begin
      res_found_r  <= found_r;
      res_status_r <= status_r;
    end
  end

  assign out_valid  = ovalid_r;
  assign out_found  = res_found_r;
  assign out_status = res_status_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_found))
    else $error("result changed while stalled");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("input accepted while busy");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK)
    else $error("found set with bad status");

endmodule
